@@ rtl/gcib_pkg.sv @@
// ----------------------------------------------------------------------------
// gcib_pkg
// Shared constants, types and tables of the great-circle bearing pipeline.
// ----------------------------------------------------------------------------
package gcib_pkg;

    // CORDIC depth and internal precision.
    localparam int CORDIC_STAGES  = 24;
    localparam int INTERNAL_WIDTH = 32;
    localparam int FRAC_BITS      = INTERNAL_WIDTH - 2;

    // Datapath widths.
    localparam int ANG_W  = 32;
    localparam int XY_W   = INTERNAL_WIDTH + 2;
    localparam int AT_W   = INTERNAL_WIDTH + 5;
    localparam int Z_W    = ANG_W + 2;
    localparam int CDEG_W = 16;
    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;

    typedef logic [ANG_W-1:0]         ang_t;
    typedef logic signed [XY_W-1:0]   xy_t;
    typedef logic signed [AT_W-1:0]   at_t;
    typedef logic signed [Z_W-1:0]    zrot_t;
    typedef logic [CDEG_W-1:0]        cdeg_t;

    localparam ang_t HALF_TURN    = ang_t'(32'h8000_0000);
    localparam ang_t QUARTER_TURN = ang_t'(32'h4000_0000);

    // CORDIC start value: 1/gain scaled to FRAC_BITS, rounded.
    localparam logic [63:0] INV_GAIN_Q32 = 64'd2608131496;
    localparam xy_t START_GAIN = xy_t'((FRAC_BITS >= 32) ?
        (INV_GAIN_Q32 << ((FRAC_BITS >= 32) ? (FRAC_BITS - 32) : 0)) :
        ((INV_GAIN_Q32 + (64'd1 << ((FRAC_BITS < 32) ? (31 - FRAC_BITS) : 0)))
            >> ((FRAC_BITS < 32) ? (32 - FRAC_BITS) : 0)));

    // atan(2^-i) as a binary angle.
    localparam int ATAN_ENTRIES = 40;
    localparam ang_t ATAN_BAM [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
        32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
        32'd0,         32'd0,         32'd0,         32'd0,        32'd0
    };

    // Conversion of 1e-7 degree units to a binary angle.
    // angle = mag + floor((mag * CONV_K + CONV_C) / CONV_D), where
    // CONV_D * 1024 is one turn in input units.
    localparam int          CONV_B_W = 51;
    localparam int          CONV_Q_W = 29;
    localparam int          CONV_R_W = 24;
    localparam int          CONV_S   = 51;
    localparam logic [63:0] CONV_K   = 64'd678679;
    localparam logic [63:0] CONV_C   = 64'd1757812;
    localparam logic [63:0] CONV_D   = 64'd3515625;
    localparam logic [63:0] CONV_M   = 64'd640511947;
    localparam int          CONV_PH_W = 49;
    localparam int          CONV_PL_W = 62;

    // Output scaling.
    localparam logic [47:0] CDEG_PER_TURN = 48'd36000;

    // Pipeline latencies of the units.
    localparam int ANG_LAT    = 5;
    localparam int SINCOS_LAT = CORDIC_STAGES + 2;
    localparam int MUL_LAT    = 2;
    localparam int ATAN_LAT   = CORDIC_STAGES + 2;

endpackage

@@ rtl/great_circle_initial_bearing.sv @@
// ----------------------------------------------------------------------------
// great_circle_initial_bearing
// Initial great-circle bearing between two points, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   A word (two points, 1e-7 degree units) is taken on each rising edge with
//   start high and busy low. busy is always low: a word can enter in every
//   cycle and many words are in flight at once.
//   Each result word appears on bearing_cdeg for one cycle with done high,
//   in input order. Throughput is one word per cycle; the latency is set by
//   the two 24-stage CORDIC pipelines in series (sine/cosine and atan2), the
//   five-stage angle conversion and the two chained two-stage multipliers.
//   The receiver cannot stall, so no result is ever held back.
//   Reset clears only the valid line; words in flight at reset are dropped
//   and no done pulse follows until new words arrive.
// ----------------------------------------------------------------------------
module great_circle_initial_bearing
    import gcib_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [LAT_W-1:0] lat_from,
    input  logic signed [LON_W-1:0] lon_from,
    input  logic signed [LAT_W-1:0] lat_to,
    input  logic signed [LON_W-1:0] lon_to,
    output logic                    done,
    output logic [CDEG_W-1:0]       bearing_cdeg
);

    localparam int MUL_DLY   = MUL_LAT;
    localparam int IDENT_DLY = SINCOS_LAT + 2 * MUL_LAT + 1 + ATAN_LAT + 1;
    localparam int TOTAL_LAT = ANG_LAT + 1 + SINCOS_LAT + 2 * MUL_LAT + 1 + ATAN_LAT + 2;

    logic  accept;
    logic  vld_reg [TOTAL_LAT];
    ang_t  lat1_ang, lon1_ang, lat2_ang, lon2_ang;
    ang_t  lat1_reg, lat2_reg, dlon_reg, dlon_next;
    logic  ident_reg;
    logic  ident_dly_reg [IDENT_DLY];
    xy_t   s1, c1, s2, c2, sd, cd;
    xy_t   cd_dly_reg [MUL_DLY];
    xy_t   y_prod, m1_prod, m2_prod, m3_prod;
    xy_t   y_dly_reg [MUL_DLY];
    xy_t   m1_dly_reg [MUL_DLY];
    logic signed [XY_W:0] x_reg;
    xy_t   y_reg;
    ang_t  bear_ang;
    logic [47:0] scl_reg, rnd_next;
    cdeg_t cdeg_next, bearing_reg;

    // The pipeline never refuses a word.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid line running alongside the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOTAL_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k < TOTAL_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Input values to binary angles.
    gcib_ang u_ang_lat1 (.clk(clk), .value(ANG_W'(lat_from)), .ang(lat1_ang));
    gcib_ang u_ang_lon1 (.clk(clk), .value(ANG_W'(lon_from)), .ang(lon1_ang));
    gcib_ang u_ang_lat2 (.clk(clk), .value(ANG_W'(lat_to)),   .ang(lat2_ang));
    gcib_ang u_ang_lon2 (.clk(clk), .value(ANG_W'(lon_to)),   .ang(lon2_ang));

    // Longitude difference and the identical-points flag.
    assign dlon_next = lon2_ang - lon1_ang;

    always_ff @(posedge clk)
    begin
        lat1_reg  <= lat1_ang;
        lat2_reg  <= lat2_ang;
        dlon_reg  <= dlon_next;
        ident_reg <= (lat1_ang == lat2_ang) && (dlon_next == '0);
    end

    // Sines and cosines of both latitudes and the longitude difference.
    gcib_sincos u_sc_lat1 (.clk(clk), .ang(lat1_reg), .sin_v(s1), .cos_v(c1));
    gcib_sincos u_sc_lat2 (.clk(clk), .ang(lat2_reg), .sin_v(s2), .cos_v(c2));
    gcib_sincos u_sc_dlon (.clk(clk), .ang(dlon_reg), .sin_v(sd), .cos_v(cd));

    // First products.
    gcib_mul u_mul_y  (.clk(clk), .a(sd), .b(c2), .p(y_prod));
    gcib_mul u_mul_m1 (.clk(clk), .a(c1), .b(s2), .p(m1_prod));
    gcib_mul u_mul_m2 (.clk(clk), .a(s1), .b(c2), .p(m2_prod));

    // Second product, with cos dlon delayed to meet it.
    gcib_mul u_mul_m3 (.clk(clk), .a(m2_prod), .b(cd_dly_reg[MUL_DLY-1]), .p(m3_prod));

    // Delay lines that keep operands aligned with the multipliers.
    always_ff @(posedge clk)
    begin
        cd_dly_reg[0] <= cd;
        y_dly_reg[0]  <= y_prod;
        m1_dly_reg[0] <= m1_prod;
        for (int k = 1; k < MUL_DLY; k++)
        begin
            cd_dly_reg[k] <= cd_dly_reg[k-1];
            y_dly_reg[k]  <= y_dly_reg[k-1];
            m1_dly_reg[k] <= m1_dly_reg[k-1];
        end
    end

    // Atan2 operands.
    always_ff @(posedge clk)
    begin
        x_reg <= (XY_W+1)'(m1_dly_reg[MUL_DLY-1]) - (XY_W+1)'(m3_prod);
        y_reg <= y_dly_reg[MUL_DLY-1];
    end

    gcib_atan u_atan (.clk(clk), .x_in(x_reg), .y_in(y_reg), .ang(bear_ang));

    // Identical-points flag follows the word down to the output.
    always_ff @(posedge clk)
    begin
        ident_dly_reg[0] <= ident_reg;
        for (int k = 1; k < IDENT_DLY; k++)
        begin
            ident_dly_reg[k] <= ident_dly_reg[k-1];
        end
    end

    // Scale the binary angle to hundredths of a degree.
    always_comb
    begin
        rnd_next = scl_reg + (48'd1 << 31);
        if (ident_dly_reg[IDENT_DLY-1] || (rnd_next[47:32] >= CDEG_W'(CDEG_PER_TURN)))
        begin
            cdeg_next = '0;
        end
        else
        begin
            cdeg_next = rnd_next[47:32];
        end
    end

    always_ff @(posedge clk)
    begin
        scl_reg     <= 48'(bear_ang) * CDEG_PER_TURN;
        bearing_reg <= cdeg_next;
    end

    assign done         = vld_reg[TOTAL_LAT-1];
    assign bearing_cdeg = bearing_reg;

`ifndef SYNTHESIS
    // Every accepted word yields a result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LAT done)
        else $error("result missing after fixed latency");

    // A delivered bearing is always inside one turn.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (bearing_cdeg < CDEG_W'(CDEG_PER_TURN)))
        else $error("bearing out of range");

    // Identical points give a zero bearing.
    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[TOTAL_LAT-2] && ident_dly_reg[IDENT_DLY-1]) |=> (bearing_cdeg == '0))
        else $error("identical points gave nonzero bearing");
`endif

endmodule

@@ rtl/gcib_ang.sv @@
// ----------------------------------------------------------------------------
// gcib_ang
// Five-stage conversion of a signed 1e-7 degree value into a binary angle.
// ----------------------------------------------------------------------------
module gcib_ang
    import gcib_pkg::*;
(
    input  logic                    clk,
    input  logic signed [ANG_W-1:0] value,
    output ang_t                    ang
);

    logic                neg_a_reg, neg_b_reg, neg_c_reg, neg_d_reg;
    logic [ANG_W-1:0]    mag_next, mag_a_reg, mag_b_reg, mag_c_reg, mag_d_reg;
    logic [CONV_B_W-1:0] b_next, b_a_reg, b_b_reg, b_c_reg;
    logic [CONV_PH_W-1:0] phi_next, phi_reg;
    logic [CONV_PL_W-1:0] plo_next, plo_reg;
    logic [80:0]         sum_next;
    logic [CONV_Q_W-1:0] q_next, q_c_reg, q_d_reg, q_fix;
    logic [CONV_R_W-1:0] rem_next, rem_d_reg;
    ang_t                r_sum, ang_next, ang_reg;

    // Stage A: magnitude and the scaled numerator.
    always_comb
    begin
        mag_next = value[ANG_W-1] ? (ANG_W'(0) - $unsigned(value)) : $unsigned(value);
        b_next   = CONV_B_W'(64'(mag_next) * CONV_K + CONV_C);
    end

    // Stage B: two partial products with the reciprocal.
    always_comb
    begin
        phi_next = CONV_PH_W'(64'(b_a_reg[CONV_B_W-1:32]) * CONV_M);
        plo_next = CONV_PL_W'(64'(b_a_reg[31:0]) * CONV_M);
    end

    // Stage C: quotient estimate, low by at most one.
    always_comb
    begin
        sum_next = {phi_reg, 32'd0} + 81'(plo_reg);
        q_next   = CONV_Q_W'(sum_next >> CONV_S);
    end

    // Stage D: remainder of the estimate.
    always_comb
    begin
        rem_next = CONV_R_W'(b_c_reg - CONV_B_W'(64'(q_c_reg) * CONV_D));
    end

    // Stage E: correct the quotient and restore the sign.
    always_comb
    begin
        q_fix    = q_d_reg + CONV_Q_W'(64'(rem_d_reg) >= CONV_D);
        r_sum    = mag_d_reg + ANG_W'(q_fix);
        ang_next = neg_d_reg ? (ANG_W'(0) - r_sum) : r_sum;
    end

    always_ff @(posedge clk)
    begin
        neg_a_reg <= value[ANG_W-1];
        mag_a_reg <= mag_next;
        b_a_reg   <= b_next;

        neg_b_reg <= neg_a_reg;
        mag_b_reg <= mag_a_reg;
        b_b_reg   <= b_a_reg;
        phi_reg   <= phi_next;
        plo_reg   <= plo_next;

        neg_c_reg <= neg_b_reg;
        mag_c_reg <= mag_b_reg;
        b_c_reg   <= b_b_reg;
        q_c_reg   <= q_next;

        neg_d_reg <= neg_c_reg;
        mag_d_reg <= mag_c_reg;
        q_d_reg   <= q_c_reg;
        rem_d_reg <= rem_next;

        ang_reg   <= ang_next;
    end

    assign ang = ang_reg;

endmodule

@@ rtl/gcib_sincos.sv @@
// ----------------------------------------------------------------------------
// gcib_sincos
// Pipelined rotation-mode CORDIC: sine and cosine of a binary angle.
// ----------------------------------------------------------------------------
module gcib_sincos
    import gcib_pkg::*;
(
    input  logic clk,
    input  ang_t ang,
    output xy_t  sin_v,
    output xy_t  cos_v
);

    xy_t   x_reg [CORDIC_STAGES+1];
    xy_t   y_reg [CORDIC_STAGES+1];
    zrot_t z_reg [CORDIC_STAGES+1];
    logic  flip_reg [CORDIC_STAGES+1];
    ang_t  rot_next, fold_next;
    xy_t   sin_reg, cos_reg;

    // Fold the angle into the right half plane.
    always_comb
    begin
        rot_next  = ang + QUARTER_TURN;
        fold_next = rot_next[ANG_W-1] ? (ang - HALF_TURN) : ang;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= START_GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= zrot_t'($signed(fold_next));
        flip_reg[0] <= rot_next[ANG_W-1];
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        xy_t   x_next, y_next;
        zrot_t z_next;

        always_comb
        begin
            if (!z_reg[i][Z_W-1])
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - zrot_t'(ATAN_BAM[i]);
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + zrot_t'(ATAN_BAM[i]);
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next;
            y_reg[i+1]    <= y_next;
            z_reg[i+1]    <= z_next;
            flip_reg[i+1] <= flip_reg[i];
        end
    end

    // Undo the fold.
    always_ff @(posedge clk)
    begin
        sin_reg <= flip_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
        cos_reg <= flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
    end

    assign sin_v = sin_reg;
    assign cos_v = cos_reg;

endmodule

@@ rtl/gcib_mul.sv @@
// ----------------------------------------------------------------------------
// gcib_mul
// Two-stage fixed-point multiply with sign-magnitude rounding.
// ----------------------------------------------------------------------------
module gcib_mul
    import gcib_pkg::*;
(
    input  logic clk,
    input  xy_t  a,
    input  xy_t  b,
    output xy_t  p
);

    logic [XY_W-1:0]   ua_next, ub_next;
    logic [2*XY_W-1:0] prod_reg, rnd_next;
    logic              neg_reg;
    xy_t               mag_next, p_reg;

    // Stage 1: product of the magnitudes.
    always_comb
    begin
        ua_next = a[XY_W-1] ? (XY_W'(0) - $unsigned(a)) : $unsigned(a);
        ub_next = b[XY_W-1] ? (XY_W'(0) - $unsigned(b)) : $unsigned(b);
    end

    // Stage 2: round half up, drop the fraction, restore the sign.
    always_comb
    begin
        rnd_next = (prod_reg + ((2*XY_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        mag_next = xy_t'(rnd_next);
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= a[XY_W-1] ^ b[XY_W-1];
        prod_reg <= (2*XY_W)'(ua_next) * (2*XY_W)'(ub_next);
        p_reg    <= neg_reg ? -mag_next : mag_next;
    end

    assign p = p_reg;

endmodule

@@ rtl/gcib_atan.sv @@
// ----------------------------------------------------------------------------
// gcib_atan
// Pipelined vectoring-mode CORDIC: atan2 of (y, x) as a binary angle.
// ----------------------------------------------------------------------------
module gcib_atan
    import gcib_pkg::*;
(
    input  logic                 clk,
    input  logic signed [XY_W:0] x_in,
    input  xy_t                  y_in,
    output ang_t                 ang
);

    at_t  x_reg [CORDIC_STAGES+1];
    at_t  y_reg [CORDIC_STAGES+1];
    ang_t z_reg [CORDIC_STAGES+1];
    logic zero_reg [CORDIC_STAGES+1];
    at_t  xe_next, ye_next;
    ang_t ang_reg;

    // Move the vector into the right half plane; the half turn goes into z.
    always_comb
    begin
        xe_next = at_t'(x_in);
        ye_next = at_t'(y_in);
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_in[XY_W] ? -xe_next : xe_next;
        y_reg[0]    <= x_in[XY_W] ? -ye_next : ye_next;
        z_reg[0]    <= x_in[XY_W] ? HALF_TURN : '0;
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        at_t  x_next, y_next;
        ang_t z_next;

        always_comb
        begin
            if (!y_reg[i][AT_W-1])
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + ATAN_BAM[i];
            end
            else
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - ATAN_BAM[i];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next;
            y_reg[i+1]    <= y_next;
            z_reg[i+1]    <= z_next;
            zero_reg[i+1] <= zero_reg[i];
        end
    end

    // A zero vector has angle zero.
    always_ff @(posedge clk)
    begin
        ang_reg <= zero_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];
    end

    assign ang = ang_reg;

endmodule
